// File: rtl/core/nssg_pkg.sv
// Package for the nested square segment generator.
// Holds widths, reset values, register indexes, the controller state type
// and the command struct shared by the controller, datapath and top level.
package nssg_pkg;

  // Defaults for the top-level parameters.
  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 160;
  localparam int FRACTION_BITS_DEF = 8;

  // Field widths.
  localparam int COORD_W    = 8;
  localparam int SIDE_W     = 8;
  localparam int COLOR_W    = 24;
  localparam int RATIO_W    = 9;
  localparam int LEVEL_W    = 5;
  localparam int LEVEL_IDX_W = 4;
  localparam int EDGE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // The ratio is Q1.8, so the interpolation step shifts by eight bits.
  localparam int LERP_SHIFT = 8;

  localparam logic [RATIO_W-1:0] RATIO_ONE   = 9'd256;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 9'd205;
  localparam logic [LEVEL_W-1:0] MAX_LEVELS  = 5'd16;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 5'd10;

  localparam logic [EDGE_W-1:0] EDGE_FIRST = 2'd0;
  localparam logic [EDGE_W-1:0] EDGE_LAST  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LERP_RATIO  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture a new parent square
    logic emit;  // produce one segment and advance the corner ring
    logic wrap;  // this segment closes the current level
    logic last;  // this segment closes the whole run
  } dp_cmd_t;

endpackage

// File: rtl/core/nssg_ctrl.sv
// Controller for the nested square segment generator.
// Sequences edges and levels and owns the output valid flag; uses nssg_pkg.
module nssg_ctrl
  import nssg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic [LEVEL_W-1:0] level_count,
  output dp_cmd_t            cmd
);

  ctrl_state_t             state_r, state_nxt;
  logic [EDGE_W-1:0]       edge_r, edge_nxt;
  logic [LEVEL_IDX_W-1:0]  level_r, level_nxt;
  logic [LEVEL_W-1:0]      levels_r, levels_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]      levels_clamped;
  logic [LEVEL_W-1:0]      levels_m1;
  logic                    accept;
  logic                    emit;
  logic                    wrap;
  logic                    last_level;

  // Level count is clamped once when the item is taken.
  assign levels_clamped = (level_count > MAX_LEVELS) ? MAX_LEVELS : level_count;
  assign levels_m1      = levels_r - 5'd1;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign emit       = (state_r == ST_RUN) && (!out_valid_r || out_ready);
  assign wrap       = (edge_r == EDGE_LAST);
  assign last_level = ({1'b0, level_r} == levels_m1);

  assign cmd.load = accept;
  assign cmd.emit = emit;
  assign cmd.wrap = wrap;
  assign cmd.last = wrap && last_level;

  assign out_valid = out_valid_r;

  // Next-state logic for the run sequencer.
  always_comb begin
    state_nxt  = state_r;
    edge_nxt   = edge_r;
    level_nxt  = level_r;
    levels_nxt = levels_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          levels_nxt = levels_clamped;
          edge_nxt   = EDGE_FIRST;
          level_nxt  = '0;
          if (levels_clamped != '0) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (emit) begin
          edge_nxt = edge_r + 2'd1;
          if (wrap) begin
            level_nxt = level_r + 4'd1;
            if (last_level) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The output slot is filled on emit and freed when the item is taken.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      edge_r      <= '0;
      level_r     <= '0;
      levels_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      edge_r      <= edge_nxt;
      level_r     <= level_nxt;
      levels_r    <= levels_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/nssg_dp.sv
// Datapath for the nested square segment generator.
// Holds the corner ring, the interpolation unit and the output registers;
// uses nssg_pkg and is driven by nssg_ctrl through dp_cmd_t.
module nssg_dp
  import nssg_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  dp_cmd_t                   cmd,
  input  logic [RATIO_W-1:0]        lerp_ratio,
  input  logic signed [COORD_W-1:0] in_corner_x,
  input  logic signed [COORD_W-1:0] in_corner_y,
  input  logic [SIDE_W-1:0]         in_side_length,
  input  logic [COLOR_W-1:0]        in_line_color,
  output logic [COORD_W-1:0]        out_start_x,
  output logic [COORD_W-1:0]        out_start_y,
  output logic [COORD_W-1:0]        out_end_x,
  output logic [COORD_W-1:0]        out_end_y,
  output logic [COLOR_W-1:0]        out_segment_color,
  output logic                      out_last_segment
);

  // Corner width: 8 integer bits plus sign and one bit of headroom for
  // corner minus side, plus the fraction.
  localparam int CW  = COORD_W + 2 + FRACTION_BITS;
  // Screen arithmetic width, wide enough for half the largest screen.
  localparam int SCW = CW + 12;
  localparam logic signed [SCW-1:0] HALF_W  = SCW'(SCREEN_WIDTH / 2) <<< FRACTION_BITS;
  localparam logic signed [SCW-1:0] HALF_H  = SCW'(SCREEN_HEIGHT / 2) <<< FRACTION_BITS;
  localparam logic signed [SCW-1:0] LIMIT_W = SCW'(SCREEN_WIDTH);
  localparam logic signed [SCW-1:0] LIMIT_H = SCW'(SCREEN_HEIGHT);

  // Floor to whole pixels, clamp to the screen and keep the low byte.
  function automatic logic [COORD_W-1:0] to_screen(input logic signed [SCW-1:0] v,
                                                   input logic signed [SCW-1:0] lim);
    logic signed [SCW-1:0] p;
    begin
      p = v >>> FRACTION_BITS;
      if (p < 0) begin
        p = '0;
      end else if (p > lim) begin
        p = lim;
      end
      return p[COORD_W-1:0];
    end
  endfunction

  // Move a toward b by lam/256, rounding the step toward minus infinity.
  function automatic logic signed [CW-1:0] lerp(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b,
                                                input logic [RATIO_W-1:0] lam);
    logic signed [CW:0]          diff;
    logic signed [CW+RATIO_W+1:0] prod;
    logic signed [CW+RATIO_W+1:0] step;
    begin
      diff = {b[CW-1], b} - {a[CW-1], a};
      prod = diff * $signed({1'b0, lam});
      step = prod >>> LERP_SHIFT;
      return a + step[CW-1:0];
    end
  endfunction

  function automatic logic signed [SCW-1:0] widen(input logic signed [CW-1:0] c);
    begin
      return {{(SCW-CW){c[CW-1]}}, c};
    end
  endfunction

  // Corner ring: position 0 is the start of the current edge, position 1
  // its end, except on the closing edge where the end is the saved first.
  logic signed [CW-1:0] cx_r [4];
  logic signed [CW-1:0] cy_r [4];
  logic signed [CW-1:0] first_x_r, first_y_r;
  logic [COLOR_W-1:0]   color_r;

  logic [RATIO_W-1:0]   lam;
  logic signed [CW-1:0] load_x, load_y, load_side;
  logic signed [CW-1:0] end_x, end_y;
  logic signed [CW-1:0] next_x, next_y;

  logic [COORD_W-1:0] start_x_r, start_y_r, end_x_r, end_y_r;
  logic [COLOR_W-1:0] seg_color_r;
  logic               last_r;

  assign lam = (lerp_ratio > RATIO_ONE) ? RATIO_ONE : lerp_ratio;

  // Parent square in fixed point.
  assign load_x    = {{(CW-COORD_W){in_corner_x[COORD_W-1]}}, in_corner_x} << FRACTION_BITS;
  assign load_y    = {{(CW-COORD_W){in_corner_y[COORD_W-1]}}, in_corner_y} << FRACTION_BITS;
  assign load_side = {{(CW-SIDE_W){1'b0}}, in_side_length} << FRACTION_BITS;

  // Edge endpoints and the interpolated corner for the next level.
  assign end_x  = cmd.wrap ? first_x_r : cx_r[1];
  assign end_y  = cmd.wrap ? first_y_r : cy_r[1];
  assign next_x = lerp(cx_r[0], end_x, lam);
  assign next_y = lerp(cy_r[0], end_y, lam);

  // Corner ring: load a new square, or rotate by one with the new corner
  // entering at the back.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r[0]   <= load_x;
      cy_r[0]   <= load_y;
      cx_r[1]   <= load_x - load_side;
      cy_r[1]   <= load_y;
      cx_r[2]   <= load_x - load_side;
      cy_r[2]   <= load_y - load_side;
      cx_r[3]   <= load_x;
      cy_r[3]   <= load_y - load_side;
      first_x_r <= load_x;
      first_y_r <= load_y;
      color_r   <= in_line_color;
    end else if (cmd.emit) begin
      cx_r[0] <= cx_r[1];
      cy_r[0] <= cy_r[1];
      cx_r[1] <= cx_r[2];
      cy_r[1] <= cy_r[2];
      cx_r[2] <= cx_r[3];
      cy_r[2] <= cy_r[3];
      cx_r[3] <= next_x;
      cy_r[3] <= next_y;
      // The first corner of the next level is the one now at position 1.
      if (cmd.wrap) begin
        first_x_r <= cx_r[1];
        first_y_r <= cy_r[1];
      end
    end
  end

  // Output item registers.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      start_x_r   <= to_screen(widen(cx_r[0]) + HALF_W, LIMIT_W);
      start_y_r   <= to_screen(HALF_H - widen(cy_r[0]), LIMIT_H);
      end_x_r     <= to_screen(widen(end_x) + HALF_W, LIMIT_W);
      end_y_r     <= to_screen(HALF_H - widen(end_y), LIMIT_H);
      seg_color_r <= color_r;
      last_r      <= cmd.last;
    end
  end

  assign out_start_x       = start_x_r;
  assign out_start_y       = start_y_r;
  assign out_end_x         = end_x_r;
  assign out_end_y         = end_y_r;
  assign out_segment_color = seg_color_r;
  assign out_last_segment  = last_r;

endmodule

// File: rtl/core/nested_square_segment_generator_unit.sv
// Top level of the nested square segment generator.
// Holds the configuration registers and joins nssg_ctrl and nssg_dp;
// uses nssg_pkg.
//
//   Channel   Direction  Handshake               Payload
//   in_       input      in_valid / in_ready     corner_x, corner_y, side_length, line_color
//   out_      output     out_valid / out_ready   start/end x and y, segment_color, last_segment
//   cfg_      input      cfg_wr_en               cfg_index, cfg_wdata
//
// A square yields level_count * 4 segments (level_count clamped to 16), one per
// cycle when the output is free; the corner ring and its single interpolation
// unit per axis set that pace.
// Reset is synchronous and active low; it returns the sequencer to idle,
// empties the output register and restores the register defaults.
// A stalled output freezes the sequencer; the next item is taken while the
// final segment still waits.
module nested_square_segment_generator_unit
  import nssg_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_corner_x,
  input  logic signed [COORD_W-1:0] in_corner_y,
  input  logic [SIDE_W-1:0]         in_side_length,
  input  logic [COLOR_W-1:0]        in_line_color,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COORD_W-1:0]        out_start_x,
  output logic [COORD_W-1:0]        out_start_y,
  output logic [COORD_W-1:0]        out_end_x,
  output logic [COORD_W-1:0]        out_end_y,
  output logic [COLOR_W-1:0]        out_segment_color,
  output logic                      out_last_segment
);

  logic [RATIO_W-1:0] lerp_ratio_r, lerp_ratio_nxt;
  logic [LEVEL_W-1:0] level_count_r, level_count_nxt;
  dp_cmd_t            cmd;

  // Configuration register writes.
  always_comb begin
    lerp_ratio_nxt  = lerp_ratio_r;
    level_count_nxt = level_count_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_LERP_RATIO:  lerp_ratio_nxt  = cfg_wdata[RATIO_W-1:0];
        REG_LEVEL_COUNT: level_count_nxt = cfg_wdata[LEVEL_W-1:0];
        default: begin
          lerp_ratio_nxt  = lerp_ratio_r;
          level_count_nxt = level_count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lerp_ratio_r  <= RATIO_RESET;
      level_count_r <= LEVEL_RESET;
    end else begin
      lerp_ratio_r  <= lerp_ratio_nxt;
      level_count_r <= level_count_nxt;
    end
  end

  nssg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .level_count (level_count_r),
    .cmd         (cmd)
  );

  nssg_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .lerp_ratio        (lerp_ratio_r),
    .in_corner_x       (in_corner_x),
    .in_corner_y       (in_corner_y),
    .in_side_length    (in_side_length),
    .in_line_color     (in_line_color),
    .out_start_x       (out_start_x),
    .out_start_y       (out_start_y),
    .out_end_x         (out_end_x),
    .out_end_y         (out_end_y),
    .out_segment_color (out_segment_color),
    .out_last_segment  (out_last_segment)
  );

endmodule
